[hdl/box_pyramid_downsampler_defines.svh]
`ifndef BOX_PYRAMID_DOWNSAMPLER_DEFINES_SVH
`define BOX_PYRAMID_DOWNSAMPLER_DEFINES_SVH

// Check a condition in the same cycle as its trigger; quiet while in reset.
`define BPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger; quiet while in reset.
`define BPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/bpd_pkg.sv]
package bpd_pkg;

    localparam int PIX_W          = 8;
    localparam int LVL_W          = 3;
    localparam int CFG_W          = 12;
    localparam int LIM_W          = 3;
    localparam int DATA_W         = 32;
    localparam int ADDR_W         = 4;
    // Results per pixel are bounded by the level index field.
    localparam int RES_MAX        = (1 << LVL_W) - 1;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_LEVELS_DEF = 8;

    localparam logic [CFG_W-1:0] BASE_WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] BASE_HEIGHT_RST = CFG_W'(480);
    localparam logic [LIM_W-1:0] LEVEL_LIMIT_RST = LIM_W'(4);
    localparam logic [CFG_W-1:0] MIN_SIZE_RST    = CFG_W'(8);

    typedef enum logic [1:0] {
        REG_BASE_WIDTH  = 2'd0,
        REG_BASE_HEIGHT = 2'd1,
        REG_LEVEL_LIMIT = 2'd2,
        REG_MIN_SIZE    = 2'd3
    } bpd_reg_t;

    // One pixel's wavefront as it walks the chain of level cells.
    typedef struct packed {
        logic                           has_pix;
        logic [PIX_W-1:0]               cur;
        logic [LVL_W-1:0]               n;
        logic [RES_MAX-1:0]             done;
        logic [RES_MAX-1:0][PIX_W-1:0]  vals;
    } bpd_tok_t;

    typedef struct packed {
        logic go;
        logic restart;
        logic build_en;
    } bpd_ctl_t;

    // Levels above the level index range are never built.
    function automatic int cell_count(input int max_levels);
        return (max_levels < RES_MAX + 1) ? max_levels : RES_MAX + 1;
    endfunction

endpackage

[hdl/box_pyramid_downsampler.sv]
// Channel   Direction  Handshake                     Beat payload
// pixel     in         pixel_valid / pixel_stall     pixel_value
// result    out        result_valid / result_stall   level_index, out_value, level_done,
//                                                    last_of_run
// config    in         APB psel/penable/pready       paddr, pwdata, prdata
//
// Throughput: one pixel beat per clock while each pixel builds at most one result and result_stall
//   is low; a pixel that builds n results holds the single result register until all n are taken,
//   so a steady run of such pixels enters only as fast as their results drain.
// Result path: a pixel beat passes from cell 0 through the tok_reg holds of cells 1 to NCELL-1
//   and then the bpd_ser result register, which drives result_valid; any of these may stall.
// Reset: rst_n clears counters, pair holds and handshake state; line stores are not cleared.
// Stalls: result_stall backs up through the elastic cell chain; bubbles collapse, so pixels
//   still enter while a result waits.
module box_pyramid_downsampler
    import bpd_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               pixel_valid,
    output logic               pixel_stall,
    input  logic [PIX_W-1:0]   pixel_value,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [LVL_W-1:0]   level_index,
    output logic [PIX_W-1:0]   out_value,
    output logic               level_done,
    output logic               last_of_run
);

    // Cell k owns level k: its counters, pair hold and line store.
    localparam int NCELL = cell_count(MAX_LEVELS);
    localparam int SW    = $clog2(MAX_WIDTH) + 1;

    logic                      restart;
    logic [NCELL-1:0][SW-1:0]  lvl_width, lvl_height;
    logic [NCELL-1:0]          build_en;

    logic [NCELL-1:0]          tv, go, space;
    logic [NCELL-1:1]          tv_reg;
    bpd_tok_t                  tok_reg [NCELL-1:1];
    bpd_tok_t                  src_tok;
    bpd_tok_t                  cell_in [NCELL];
    bpd_tok_t                  cell_out [NCELL];
    bpd_ctl_t                  ctl [NCELL];
    logic                      ser_free;

    bpd_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .restart    (restart),
        .lvl_width  (lvl_width),
        .lvl_height (lvl_height),
        .build_en   (build_en)
    );

    // The pixel beat enters cell 0 directly.
    always_comb
    begin
        src_tok         = '0;
        src_tok.has_pix = 1'b1;
        src_tok.cur     = pixel_value;
    end

    assign tv[0]       = pixel_valid;
    assign tv[NCELL-1:1] = tv_reg;

    // Advance a wavefront when the slot ahead is empty or moving too.
    always_comb
    begin
        space[NCELL-1] = ser_free;
        go[NCELL-1]    = tv[NCELL-1] && space[NCELL-1];
        for (int k = NCELL - 2; k >= 0; k--)
        begin
            space[k] = !tv[k+1] || go[k+1];
            go[k]    = tv[k] && space[k];
        end
    end

    assign pixel_stall = !space[0];

    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        if (k > 0)
        begin : g_in
            assign cell_in[k] = tok_reg[k];
        end
        else
        begin : g_src
            assign cell_in[k] = src_tok;
        end

        assign ctl[k] = '{go: go[k], restart: restart, build_en: build_en[k]};

        bpd_cell #(
            .LEVEL     (k),
            .MAX_WIDTH (MAX_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl[k]),
            .lvl_width  (lvl_width[k]),
            .lvl_height (lvl_height[k]),
            .tok_in     (cell_in[k]),
            .tok_out    (cell_out[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg <= '0;
        end
        else
        begin
            for (int k = 1; k < NCELL; k++)
            begin
                if (go[k-1])
                    tv_reg[k] <= 1'b1;
                else if (go[k])
                    tv_reg[k] <= 1'b0;
            end
        end
    end

    // Hold each wavefront until the next cell takes it.
    always_ff @(posedge clk)
    begin
        for (int k = 1; k < NCELL; k++)
        begin
            if (go[k-1])
                tok_reg[k] <= cell_out[k-1];
        end
    end

    // Drain a finished wavefront one level per result beat.
    bpd_ser u_ser (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (go[NCELL-1]),
        .tok          (cell_out[NCELL-1]),
        .free         (ser_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .level_index  (level_index),
        .out_value    (out_value),
        .level_done   (level_done),
        .last_of_run  (last_of_run)
    );

endmodule

[hdl/bpd_cell.sv]
`include "box_pyramid_downsampler_defines.svh"

module bpd_cell
    import bpd_pkg::*;
#(
    parameter int LEVEL     = 0,
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int CW       = $clog2(MAX_WIDTH),
    localparam int SW       = CW + 1
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  bpd_ctl_t       ctl,
    input  logic [SW-1:0]  lvl_width,
    input  logic [SW-1:0]  lvl_height,
    input  bpd_tok_t       tok_in,
    output bpd_tok_t       tok_out
);

    localparam int AW    = CW - 1;
    localparam int DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int VI    = (LEVEL < RES_MAX) ? LEVEL : RES_MAX - 1;
    localparam int DI    = (LEVEL > 0) ? LEVEL - 1 : 0;

    logic [CW-1:0]     col_reg, col_next;
    logic [CW-1:0]     row_reg, row_next;
    logic [PIX_W-1:0]  hold_reg;
    logic [PIX_W:0]    line_mem [DEPTH];
    logic [PIX_W:0]    rd_reg;

    logic              take, last_col, last_row, pair_ok, sum_ok, build;
    logic              hold_we, line_we;
    logic [PIX_W:0]    pair;
    logic [PIX_W+1:0]  sum;
    logic [AW-1:0]     waddr, raddr;

    always_comb
    begin
        take     = ctl.go && tok_in.has_pix;
        last_col = ({1'b0, col_reg} + SW'(1)) >= lvl_width;
        last_row = ({1'b0, row_reg} + SW'(1)) >= lvl_height;
        pair_ok  = col_reg[0] || last_col;
        sum_ok   = row_reg[0] || last_row;
        // An odd-width edge pixel pairs with itself.
        pair     = col_reg[0] ? ({1'b0, hold_reg} + {1'b0, tok_in.cur})
                              : {tok_in.cur, 1'b0};
        // An odd-height edge row pairs with itself.
        sum      = row_reg[0] ? ({1'b0, rd_reg} + {1'b0, pair}) : {pair, 1'b0};
        build    = tok_in.has_pix && ctl.build_en && pair_ok && sum_ok;
        hold_we  = take && ctl.build_en && !pair_ok;
        line_we  = take && ctl.build_en && pair_ok && !sum_ok;

        col_next = col_reg;
        row_next = row_reg;
        if (ctl.restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (take)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + CW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end

        waddr = col_reg[CW-1:1];
        // Prefetch for the column this cell sees next.
        raddr = col_next[CW-1:1];
    end

    always_comb
    begin
        tok_out         = tok_in;
        tok_out.has_pix = build;
        if ((LEVEL > 0) && tok_in.has_pix)
        begin
            tok_out.done[DI] = last_col && last_row;
        end
        if (build)
        begin
            tok_out.cur      = sum[PIX_W+1:2];
            tok_out.vals[VI] = sum[PIX_W+1:2];
            tok_out.n        = LVL_W'(LEVEL + 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            hold_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (ctl.restart)
            begin
                hold_reg <= '0;
            end
            else if (hold_we)
            begin
                hold_reg <= tok_in.cur;
            end
        end
    end

    // Even-row pair sums; write-first so a one-pair-wide level reads its own write.
    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[waddr] <= pair;
        end
        if (line_we && (waddr == raddr))
        begin
            rd_reg <= pair;
        end
        else
        begin
            rd_reg <= line_mem[raddr];
        end
    end

    `BPD_ASSERT_NOW(a_store_xor_build, line_we, !build, "line store write with a built pixel")
    `BPD_ASSERT_NEXT(a_restart_clears, ctl.restart, (col_reg == '0) && (row_reg == '0), "restart left counters")
    `BPD_ASSERT_NEXT(a_idle_holds, !ctl.restart && !take, $stable(col_reg) && $stable(row_reg), "counters moved without a pixel")

endmodule

[hdl/bpd_cfg.sv]
module bpd_cfg
    import bpd_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    localparam int NCELL     = cell_count(MAX_LEVELS),
    localparam int SW        = $clog2(MAX_WIDTH) + 1
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready,
    output logic                       restart,
    output logic [NCELL-1:0][SW-1:0]   lvl_width,
    output logic [NCELL-1:0][SW-1:0]   lvl_height,
    output logic [NCELL-1:0]           build_en
);

    logic [CFG_W-1:0]  base_width_reg, base_height_reg, min_size_reg;
    logic [LIM_W-1:0]  level_limit_reg;
    logic [SW-1:0]     w0, h0;
    logic [NCELL-1:0]  ok;
    bpd_reg_t          sel;

    assign pready  = 1'b1;
    assign sel     = bpd_reg_t'(paddr[ADDR_W-1:2]);
    assign restart = psel && penable && pwrite && pready;

    always_comb
    begin
        case (sel)
            REG_BASE_WIDTH:  prdata = DATA_W'(base_width_reg);
            REG_BASE_HEIGHT: prdata = DATA_W'(base_height_reg);
            REG_LEVEL_LIMIT: prdata = DATA_W'(level_limit_reg);
            REG_MIN_SIZE:    prdata = DATA_W'(min_size_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_width_reg  <= BASE_WIDTH_RST;
            base_height_reg <= BASE_HEIGHT_RST;
            level_limit_reg <= LEVEL_LIMIT_RST;
            min_size_reg    <= MIN_SIZE_RST;
        end
        else if (restart)
        begin
            case (sel)
                REG_BASE_WIDTH:  base_width_reg  <= pwdata[CFG_W-1:0];
                REG_BASE_HEIGHT: base_height_reg <= pwdata[CFG_W-1:0];
                REG_LEVEL_LIMIT: level_limit_reg <= pwdata[LIM_W-1:0];
                REG_MIN_SIZE:    min_size_reg    <= pwdata[CFG_W-1:0];
                default:         base_width_reg  <= base_width_reg;
            endcase
        end
    end

    // Zero sizes count as one; oversize is saturated.
    always_comb
    begin
        if (base_width_reg == '0)
            w0 = SW'(1);
        else if (32'(base_width_reg) > 32'(MAX_WIDTH))
            w0 = SW'(MAX_WIDTH);
        else
            w0 = SW'(base_width_reg);

        if (base_height_reg == '0)
            h0 = SW'(1);
        else if (32'(base_height_reg) > 32'(MAX_WIDTH))
            h0 = SW'(MAX_WIDTH);
        else
            h0 = SW'(base_height_reg);
    end

    always_comb
    begin
        for (int k = 0; k < NCELL; k++)
        begin
            lvl_width[k]  = SW'((32'(w0) + (32'd1 << k) - 32'd1) >> k);
            lvl_height[k] = SW'((32'(h0) + (32'd1 << k) - 32'd1) >> k);
        end
        ok[0] = 1'b1;
        for (int k = 1; k < NCELL; k++)
        begin
            ok[k] = ok[k-1] && (32'(level_limit_reg) >= 32'(k))
                    && (32'(lvl_width[k-1]) >= 32'(min_size_reg))
                    && (32'(lvl_height[k-1]) >= 32'(min_size_reg));
        end
        for (int k = 0; k < NCELL - 1; k++)
        begin
            build_en[k] = ok[k+1];
        end
        build_en[NCELL-1] = 1'b0;
    end

endmodule

[hdl/bpd_ser.sv]
`include "box_pyramid_downsampler_defines.svh"

module bpd_ser
    import bpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  bpd_tok_t          tok,
    output logic              free,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [LVL_W-1:0]  level_index,
    output logic [PIX_W-1:0]  out_value,
    output logic              level_done,
    output logic              last_of_run
);

    logic                           valid_reg;
    logic [LVL_W-1:0]               idx_reg, cnt_reg;
    logic [RES_MAX-1:0]             done_reg;
    logic [RES_MAX-1:0][PIX_W-1:0]  vals_reg;
    logic                           last;

    assign last         = (idx_reg + LVL_W'(1)) == cnt_reg;
    assign free         = !valid_reg || (!result_stall && last);
    assign result_valid = valid_reg;
    assign level_index  = idx_reg + LVL_W'(1);
    assign out_value    = vals_reg[idx_reg];
    assign level_done   = done_reg[idx_reg];
    assign last_of_run  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (load)
        begin
            // A pixel that built nothing leaves the register empty.
            valid_reg <= (tok.n != '0);
            idx_reg   <= '0;
            cnt_reg   <= tok.n;
        end
        else if (valid_reg && !result_stall)
        begin
            if (last)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + LVL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            vals_reg <= tok.vals;
            done_reg <= tok.done;
        end
    end

    `BPD_ASSERT_NOW(a_idx_in_run, valid_reg, idx_reg < cnt_reg, "result index past run length")
    `BPD_ASSERT_NEXT(a_run_restarts, valid_reg && !result_stall && last, !valid_reg || (idx_reg == '0), "next run not at first level")
    `BPD_ASSERT_NEXT(a_idx_steps, valid_reg && !result_stall && !last, idx_reg == ($past(idx_reg) + 1'b1), "result index skipped")

endmodule
